// ===== hw/rtl/gtscc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtscc_pkg: shared definitions for the three-symbol chain counter
// Sizes, register codes, reset values, line buffer layout and the
// saturating table arithmetic used by the update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gtscc_pkg;

    // Frame limits and count widths
    localparam int MAX_ROWS        = 1024;
    localparam int MAX_COLS        = 1024;
    localparam int COUNT_WIDTH     = 64;
    localparam int SINGLE_WIDTH    = 21;
    localparam int SYM_WIDTH       = 8;
    localparam int SIZE_WIDTH      = 11;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 11;

    localparam int ROW_WIDTH = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_WIDTH = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int POS_WIDTH = (ROW_WIDTH > COL_WIDTH) ? ROW_WIDTH : COL_WIDTH;
    // wide enough for a size register, a clamp limit and a position plus one
    localparam int EXT_WIDTH = (SIZE_WIDTH > POS_WIDTH + 1) ? SIZE_WIDTH : POS_WIDTH + 1;

    // Result queue
    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_W = 2;
    localparam int RESULT_CNT_W = 3;

    // Register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ROW_COUNT     = 3'd0,
        CFG_COL_COUNT     = 3'd1,
        CFG_FIRST_SYMBOL  = 3'd2,
        CFG_SECOND_SYMBOL = 3'd3,
        CFG_THIRD_SYMBOL  = 3'd4
    } cfg_index_t;

    // Register reset values
    localparam logic [SIZE_WIDTH-1:0] ROW_COUNT_RESET    = SIZE_WIDTH'(3);
    localparam logic [SIZE_WIDTH-1:0] COL_COUNT_RESET    = SIZE_WIDTH'(3);
    localparam logic [SYM_WIDTH-1:0]  FIRST_SYMBOL_RESET  = SYM_WIDTH'(58);
    localparam logic [SYM_WIDTH-1:0]  SECOND_SYMBOL_RESET = SYM_WIDTH'(45);
    localparam logic [SYM_WIDTH-1:0]  THIRD_SYMBOL_RESET  = SYM_WIDTH'(41);

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Saturation limits, both held at full count width
    localparam count_t SINGLE_MAX = COUNT_WIDTH'({SINGLE_WIDTH{1'b1}});
    localparam count_t COUNT_MAX  = {COUNT_WIDTH{1'b1}};

    // One line buffer entry: the three table values of one column
    typedef struct packed {
        count_t                  triples;
        count_t                  pairs;
        logic [SINGLE_WIDTH-1:0] singles;
    } line_entry_t;

    localparam int LINE_WIDTH = $bits(line_entry_t);

    // One result item
    typedef struct packed {
        logic   saturated;
        count_t triple_count;
    } result_t;

    // Upper term of a table update, ready to be combined with the left value
    typedef struct packed {
        count_t               v;
        logic [COUNT_WIDTH:0] w;
        logic                 pre_clip;
    } partial_t;

    typedef struct packed {
        count_t value;
        logic   clip;
    } table_out_t;

    // Upper minus diagonal (floored at zero), plus the increment
    function automatic partial_t table_prepare(count_t up, count_t diag, count_t inc,
                                               count_t max);
        partial_t p;
        p.v        = (diag > up) ? '0 : up - diag;
        p.w        = {1'b0, p.v} + {1'b0, inc};
        p.pre_clip = (up >= max) || (inc >= max);
        return p;
    endfunction

    // Add the left value and clip; a sum that reaches the limit before the
    // increment is added counts as a clip too
    function automatic table_out_t table_finish(partial_t p, count_t left, count_t max);
        logic [COUNT_WIDTH:0]   s1;
        logic [COUNT_WIDTH+1:0] s2;
        table_out_t             o;
        s1      = {1'b0, p.v} + {1'b0, left};
        s2      = {1'b0, p.w} + {2'b00, left};
        o.clip  = p.pre_clip || (left >= max) || (s1 >= {1'b0, max}) || (s2 > {2'b00, max});
        o.value = o.clip ? max : s2[COUNT_WIDTH-1:0];
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/grid_three_symbol_chain_counter.sv =====
// ----------------------------------------------------------------------------
// grid_three_symbol_chain_counter: chain counter over a raster symbol matrix
// Counts first/second/third symbol triples at strictly increasing row and
// column positions with three chained summed-area tables kept in one line
// buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one 8-bit symbol per transfer, row by row. After the last
//   symbol of a frame (row_count x col_count) one result appears on m_*:
//   m_tdata holds the 64-bit chain count, m_tuser the saturation flag.
//   Other symbols produce no result.
//   cfg_wr_en/cfg_index/cfg_wdata write the five registers; unknown indexes
//   are dropped.
// Timing:
//   Three stages: accept and RAM read, upper/diagonal terms, left term and
//   write-back. A result is pushed into the result queue by the write-back stage.
//   One symbol per cycle for frames of three or more columns while the result
//   queue has room. A symbol that would read the line buffer entry still being
//   written by one of the two stages ahead waits, so at one or two columns a
//   symbol below the top row waits for the write-back of its column.
// Reset and stall:
//   After reset the line buffer is cleared one column per cycle, all MAX_COLS
//   (1024) entries, with s_tready low. A four-entry result queue absorbs a
//   stalled receiver; s_tready also drops when the queue and the results
//   still in flight fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_three_symbol_chain_counter (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // input symbols; tdata: [7:0] symbol
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [7:0]                             s_tdata,
    // results; tdata: [63:0] triple_count
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [63:0]                                 m_tdata,
    // tuser: [0] saturated
    output logic [0:0]                                  m_tuser,
    // register writes
    input  wire logic                                   cfg_wr_en,
    input  wire logic [gtscc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [gtscc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

    localparam int COLW = gtscc_pkg::COL_WIDTH;
    localparam int ROWW = gtscc_pkg::ROW_WIDTH;
    localparam int EXTW = gtscc_pkg::EXT_WIDTH;
    localparam int CW   = gtscc_pkg::COUNT_WIDTH;
    localparam int SW   = gtscc_pkg::SINGLE_WIDTH;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gtscc_pkg::SIZE_WIDTH-1:0] row_count_reg, col_count_reg;
    logic [gtscc_pkg::SYM_WIDTH-1:0]  first_symbol_reg, second_symbol_reg, third_symbol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg     <= gtscc_pkg::ROW_COUNT_RESET;
            col_count_reg     <= gtscc_pkg::COL_COUNT_RESET;
            first_symbol_reg  <= gtscc_pkg::FIRST_SYMBOL_RESET;
            second_symbol_reg <= gtscc_pkg::SECOND_SYMBOL_RESET;
            third_symbol_reg  <= gtscc_pkg::THIRD_SYMBOL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gtscc_pkg::CFG_ROW_COUNT: begin
                    row_count_reg <= cfg_wdata[gtscc_pkg::SIZE_WIDTH-1:0];
                end
                gtscc_pkg::CFG_COL_COUNT: begin
                    col_count_reg <= cfg_wdata[gtscc_pkg::SIZE_WIDTH-1:0];
                end
                gtscc_pkg::CFG_FIRST_SYMBOL: begin
                    first_symbol_reg <= cfg_wdata[gtscc_pkg::SYM_WIDTH-1:0];
                end
                gtscc_pkg::CFG_SECOND_SYMBOL: begin
                    second_symbol_reg <= cfg_wdata[gtscc_pkg::SYM_WIDTH-1:0];
                end
                gtscc_pkg::CFG_THIRD_SYMBOL: begin
                    third_symbol_reg <= cfg_wdata[gtscc_pkg::SYM_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective frame size: zero acts as one, clamp to MAX_ROWS and MAX_COLS
    logic [EXTW-1:0] rows_ext, cols_ext, rows_eff, cols_eff;

    always_comb begin
        rows_ext = EXTW'(row_count_reg);
        cols_ext = EXTW'(col_count_reg);
        if (rows_ext == '0) begin
            rows_eff = EXTW'(1);
        end else if (rows_ext > EXTW'(gtscc_pkg::MAX_ROWS)) begin
            rows_eff = EXTW'(gtscc_pkg::MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        if (cols_ext == '0) begin
            cols_eff = EXTW'(1);
        end else if (cols_ext > EXTW'(gtscc_pkg::MAX_COLS)) begin
            cols_eff = EXTW'(gtscc_pkg::MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
    end

    // ------------------------------------------------------------------
    // Declarations shared by the stages
    // ------------------------------------------------------------------
    logic                           clearing_reg;
    logic [COLW-1:0]                clear_addr_reg;

    logic [ROWW-1:0]                row_pos_reg, row_pos_next;
    logic [COLW-1:0]                col_pos_reg, col_pos_next;

    logic                           b_valid_reg, b_top_reg, b_first_reg, b_last_reg;
    logic [COLW-1:0]                b_addr_reg;
    logic [2:0]                     b_match_reg;

    logic                           c_valid_reg, c_first_reg, c_last_reg;
    logic [COLW-1:0]                c_addr_reg;
    gtscc_pkg::partial_t            c_part_s_reg, c_part_p_reg, c_part_t_reg;

    logic [SW-1:0]                  diag_s_reg, left_s_reg;
    gtscc_pkg::count_t              diag_p_reg, diag_t_reg, left_p_reg, left_t_reg;
    logic                           clip_flag_reg;

    gtscc_pkg::line_entry_t         rd_entry, wr_entry, new_entry;
    logic [gtscc_pkg::LINE_WIDTH-1:0] rd_bits;
    logic                           ram_wr_en;
    logic [COLW-1:0]                ram_wr_addr;

    logic [gtscc_pkg::RESULT_CNT_W-1:0] fifo_count, pend_count;
    logic                           accept, top_a, hazard, room, last_col, last_row;
    gtscc_pkg::result_t             result, out_result;
    logic                           result_push;

    // ------------------------------------------------------------------
    // Line buffer clearing pass after reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clearing_reg) begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == COLW'(gtscc_pkg::MAX_COLS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: accept a symbol, advance the raster position, issue the read
    // ------------------------------------------------------------------
    assign top_a  = (row_pos_reg == '0);
    // hold a symbol whose column is still being written by a stage ahead
    assign hazard = !top_a && ((b_valid_reg && (b_addr_reg == col_pos_reg)) ||
                               (c_valid_reg && (c_addr_reg == col_pos_reg)));
    assign pend_count = gtscc_pkg::RESULT_CNT_W'(b_valid_reg && b_last_reg)
                      + gtscc_pkg::RESULT_CNT_W'(c_valid_reg && c_last_reg)
                      + fifo_count;
    assign room     = (pend_count < gtscc_pkg::RESULT_CNT_W'(gtscc_pkg::RESULT_DEPTH));
    assign s_tready = !clearing_reg && !hazard && room;
    assign accept   = s_tvalid && s_tready;

    assign last_col = (EXTW'(col_pos_reg) + EXTW'(1)) >= cols_eff;
    assign last_row = (EXTW'(row_pos_reg) + EXTW'(1)) >= rows_eff;

    always_comb begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (accept) begin
            if (last_col) begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + 1'b1;
            end else begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_addr_reg     <= col_pos_reg;
            b_top_reg      <= top_a;
            b_first_reg    <= (col_pos_reg == '0);
            b_last_reg     <= last_col && last_row;
            b_match_reg[0] <= (s_tdata == first_symbol_reg);
            b_match_reg[1] <= (s_tdata == second_symbol_reg);
            b_match_reg[2] <= (s_tdata == third_symbol_reg);
        end
    end

    // ------------------------------------------------------------------
    // Line buffer
    // ------------------------------------------------------------------
    assign ram_wr_en   = clearing_reg || c_valid_reg;
    assign ram_wr_addr = clearing_reg ? clear_addr_reg : c_addr_reg;
    assign wr_entry    = clearing_reg ? '0 : new_entry;

    gtscc_ram #(
        .WIDTH (gtscc_pkg::LINE_WIDTH),
        .DEPTH (gtscc_pkg::MAX_COLS)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (rd_bits)
    );

    assign rd_entry = rd_bits;

    // ------------------------------------------------------------------
    // Stage B: upper and diagonal terms plus increments
    // ------------------------------------------------------------------
    gtscc_pkg::count_t   us, up, ut, ds, dp, dt, inc_s, inc_p, inc_t;
    gtscc_pkg::partial_t part_s, part_p, part_t;

    always_comb begin
        us    = b_top_reg ? '0 : CW'(rd_entry.singles);
        up    = b_top_reg ? '0 : rd_entry.pairs;
        ut    = b_top_reg ? '0 : rd_entry.triples;
        ds    = (b_top_reg || b_first_reg) ? '0 : CW'(diag_s_reg);
        dp    = (b_top_reg || b_first_reg) ? '0 : diag_p_reg;
        dt    = (b_top_reg || b_first_reg) ? '0 : diag_t_reg;
        inc_s = b_match_reg[0] ? CW'(1) : '0;
        inc_p = b_match_reg[1] ? ds : '0;
        inc_t = b_match_reg[2] ? dp : '0;
        part_s = gtscc_pkg::table_prepare(us, ds, inc_s, gtscc_pkg::SINGLE_MAX);
        part_p = gtscc_pkg::table_prepare(up, dp, inc_p, gtscc_pkg::COUNT_MAX);
        part_t = gtscc_pkg::table_prepare(ut, dt, inc_t, gtscc_pkg::COUNT_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
        end
    end

    // this column's upper value becomes the next column's diagonal
    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            diag_s_reg   <= us[SW-1:0];
            diag_p_reg   <= up;
            diag_t_reg   <= ut;
            c_part_s_reg <= part_s;
            c_part_p_reg <= part_p;
            c_part_t_reg <= part_t;
            c_addr_reg   <= b_addr_reg;
            c_first_reg  <= b_first_reg;
            c_last_reg   <= b_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: add the left term, clip, write back
    // ------------------------------------------------------------------
    gtscc_pkg::count_t     ls, lp, lt;
    gtscc_pkg::table_out_t out_s, out_p, out_t;
    logic                  clip_any;

    always_comb begin
        ls    = c_first_reg ? '0 : CW'(left_s_reg);
        lp    = c_first_reg ? '0 : left_p_reg;
        lt    = c_first_reg ? '0 : left_t_reg;
        out_s = gtscc_pkg::table_finish(c_part_s_reg, ls, gtscc_pkg::SINGLE_MAX);
        out_p = gtscc_pkg::table_finish(c_part_p_reg, lp, gtscc_pkg::COUNT_MAX);
        out_t = gtscc_pkg::table_finish(c_part_t_reg, lt, gtscc_pkg::COUNT_MAX);
        clip_any = out_s.clip || out_p.clip || out_t.clip;
        new_entry.singles = out_s.value[SW-1:0];
        new_entry.pairs   = out_p.value;
        new_entry.triples = out_t.value;
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg) begin
            left_s_reg <= out_s.value[SW-1:0];
            left_p_reg <= out_p.value;
            left_t_reg <= out_t.value;
        end
    end

    // Collect clips over the frame, drop the flag at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_flag_reg <= 1'b0;
        end else if (c_valid_reg) begin
            clip_flag_reg <= c_last_reg ? 1'b0 : (clip_flag_reg || clip_any);
        end
    end

    assign result_push         = c_valid_reg && c_last_reg;
    assign result.triple_count = out_t.value;
    assign result.saturated    = clip_flag_reg || clip_any;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    gtscc_result_fifo u_result_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (result_push),
        .push_data  (result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_result),
        .fill_count (fifo_count)
    );

    assign m_tdata    = out_result.triple_count;
    assign m_tuser[0] = out_result.saturated;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_update_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !(b_valid_reg || c_valid_reg))
        else $error("pipeline active during line buffer clearing");

    a_clear_covers_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> $past(clear_addr_reg == COLW'(gtscc_pkg::MAX_COLS - 1)))
        else $error("clearing pass ended early");

    a_queue_never_overflows: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_count <= gtscc_pkg::RESULT_CNT_W'(gtscc_pkg::RESULT_DEPTH))
        else $error("results in flight exceed queue depth");

    a_result_from_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(c_valid_reg && c_last_reg))
        else $error("result appeared without a frame end");

endmodule

`default_nettype wire

// ===== hw/rtl/gtscc_ram.sv =====
// ----------------------------------------------------------------------------
// gtscc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. A read of the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module gtscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gtscc_result_fifo.sv =====
// ----------------------------------------------------------------------------
// gtscc_result_fifo: small queue for frame results
// Holds finished results while the receiver stalls, so the update pipeline
// keeps moving. The producer checks the fill count before it commits items.
// ----------------------------------------------------------------------------
`default_nettype none

module gtscc_result_fifo (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                push,
    input  wire gtscc_pkg::result_t                  push_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output gtscc_pkg::result_t                       out_data,
    output logic [gtscc_pkg::RESULT_CNT_W-1:0]       fill_count
);

    gtscc_pkg::result_t                     entry_reg [gtscc_pkg::RESULT_DEPTH];
    logic [gtscc_pkg::RESULT_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [gtscc_pkg::RESULT_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [gtscc_pkg::RESULT_CNT_W-1:0]     count_reg, count_next;
    logic                                   pop;

    assign out_valid  = (count_reg != '0);
    assign out_data   = entry_reg[rd_ptr_reg];
    assign fill_count = count_reg;
    assign pop        = out_valid && out_ready;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire
